// ===== design/rmh_pkg.sv =====
// ----------------------------------------------------------------------------
// rmh_pkg: running median package
// Sequencer state type and heap operation codes shared by the median block.
// ----------------------------------------------------------------------------
package rmh_pkg;

    localparam int SampleWidth = 32;
    localparam int MedianWidth = 33;
    localparam int CountWidth  = 12;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_DECIDE   = 11'b00000000010,
        ST_OP       = 11'b00000000100,
        ST_UP_RD    = 11'b00000001000,
        ST_UP_CMP   = 11'b00000010000,
        ST_POP_RD   = 11'b00000100000,
        ST_POP_WAIT = 11'b00001000000,
        ST_DN_RDL   = 11'b00010000000,
        ST_DN_RDR   = 11'b00100000000,
        ST_DN_CMP   = 11'b01000000000,
        ST_DONE     = 11'b10000000000
    } state_t;

    // queued heap operations
    typedef enum logic [2:0] {
        OP_NONE    = 3'b000,
        OP_PUSH    = 3'b001,
        OP_REPLACE = 3'b010,
        OP_POP     = 3'b011,
        OP_CHECK   = 3'b100
    } op_t;

endpackage

// ===== design/rmh_ram.sv =====
// ----------------------------------------------------------------------------
// rmh_ram: single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module rmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== design/running_median_two_heaps.sv =====
// ----------------------------------------------------------------------------
// running_median_two_heaps: running median over two heaps
// Max-heap of the lower half, min-heap of the upper half, driven by one shared
// sift sequencer.
// ----------------------------------------------------------------------------
// An item takes a variable time, set by the heap sifts on single-port
// RAMs: a sift-up reads the parent and then compares per level, a sift-down reads
// the left child, the right child and then compares, a pop first fetches the last
// entry, and an item runs at most a push, a pop and a second push, or a
// replace and a push. busy rises on the accepted start; a dropped sample goes
// from the decide state straight to done. busy falls right after the done
// cycle. The strobe marks median_doubled, stored_count and full_drop for one
// cycle and cannot be stalled. No clearing pass is needed after reset: only
// entries below the counts are ever used.
module running_median_two_heaps #(
    parameter int HEAP_DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [rmh_pkg::SampleWidth-1:0] sample,
    output logic                                   busy,
    output logic                                   done,
    output logic signed [rmh_pkg::MedianWidth-1:0] median_doubled,
    output logic [rmh_pkg::CountWidth-1:0]         stored_count,
    output logic                                   full_drop
);

    localparam int SW   = rmh_pkg::SampleWidth;
    localparam int CNTW = rmh_pkg::CountWidth;
    localparam int AW   = $clog2(HEAP_DEPTH);
    localparam int NW   = AW + 1;
    localparam int CW   = AW + 2;
    localparam logic [NW-1:0] DEPTH_N = NW'(HEAP_DEPTH);
    localparam logic [NW:0]   FULL_N  = (NW+1)'(2 * HEAP_DEPTH);

    // "x before y" in heap order: max-heap x >= y, min-heap x <= y
    function automatic logic ord(input logic h, input logic signed [SW-1:0] x,
                                 input logic signed [SW-1:0] y);
        ord = h ? (x <= y) : (x >= y);
    endfunction

    rmh_pkg::state_t state_reg, state_next;
    rmh_pkg::op_t    op0_reg, op1_reg;    // queued ops
    logic            hp0_reg, hp1_reg;

    logic [NW-1:0]        cnt_reg [2];
    logic signed [SW-1:0] root_reg [2];
    logic signed [SW-1:0] sample_reg;
    logic signed [SW-1:0] carry_reg;      // value for the next push or replace
    logic signed [SW-1:0] val_reg;        // value being sifted
    logic signed [SW-1:0] lch_reg;
    logic [AW-1:0]        idx_reg;
    logic [NW-1:0]        n_reg;          // heap size for sift-down
    logic                 heap_reg;       // 0 lower (max), 1 upper (min)
    logic                 drop_reg;

    logic                 we_c;
    logic [AW-1:0]        addr_c;
    logic [SW-1:0]        wd_c;
    logic                 we_h [2];
    logic [SW-1:0]        rdata [2];

    logic signed [SW-1:0] rd;
    logic [AW-1:0]        parent;
    logic [CW-1:0]        lchild, rchild, n_ext;
    logic                 l_ok, r_ok;
    logic signed [SW-1:0] best_v;
    logic                 take_l, take_r;
    logic                 up_move;
    logic                 tgt;
    logic [NW:0]          total;
    logic signed [SW:0]   med_c;

    for (genvar g = 0; g < 2; g++)
    begin : g_heap
        assign we_h[g] = we_c && (heap_reg == 1'(g));
        rmh_ram #(.WIDTH(SW), .DEPTH(HEAP_DEPTH)) u_ram (
            .clk   (clk),
            .we    (we_h[g]),
            .addr  (addr_c),
            .wdata (wd_c),
            .rdata (rdata[g])
        );
    end

    assign rd     = heap_reg ? rdata[1] : rdata[0];
    assign parent = (idx_reg - AW'(1)) >> 1;
    assign lchild = {1'b0, idx_reg, 1'b1};
    assign rchild = lchild + CW'(1);
    assign n_ext  = CW'(n_reg);
    assign l_ok   = lchild < n_ext;
    assign r_ok   = rchild < n_ext;

    assign take_l  = l_ok && !ord(heap_reg, val_reg, lch_reg);
    assign best_v  = take_l ? lch_reg : val_reg;
    assign take_r  = r_ok && !ord(heap_reg, best_v, rd);
    assign up_move = (idx_reg != '0) && !ord(heap_reg, rd, val_reg);

    assign tgt   = !((cnt_reg[0] == '0) || (sample_reg <= root_reg[0]));
    assign total = {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};

    // RAM port
    always_comb
    begin
        addr_c = idx_reg;
        we_c   = 1'b0;
        wd_c   = val_reg;
        unique case (state_reg)
            rmh_pkg::ST_UP_RD:  addr_c = parent;
            rmh_pkg::ST_POP_RD: addr_c = n_reg[AW-1:0];
            rmh_pkg::ST_DN_RDL: addr_c = lchild[AW-1:0];
            rmh_pkg::ST_DN_RDR: addr_c = rchild[AW-1:0];
            rmh_pkg::ST_UP_CMP:
            begin
                we_c = 1'b1;
                wd_c = up_move ? rd : val_reg;
            end
            rmh_pkg::ST_DN_CMP:
            begin
                we_c = 1'b1;
                wd_c = take_r ? rd : best_v;
            end
            default: ;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rmh_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rmh_pkg::ST_DECIDE;
                end
            end
            rmh_pkg::ST_DECIDE: state_next = drop_reg ? rmh_pkg::ST_DONE : rmh_pkg::ST_OP;
            rmh_pkg::ST_OP:
            begin
                unique case (op0_reg)
                    rmh_pkg::OP_PUSH:    state_next = rmh_pkg::ST_UP_RD;
                    rmh_pkg::OP_REPLACE: state_next = rmh_pkg::ST_DN_RDL;
                    rmh_pkg::OP_POP:     state_next = rmh_pkg::ST_POP_RD;
                    rmh_pkg::OP_CHECK:   state_next = rmh_pkg::ST_OP;
                    default:             state_next = rmh_pkg::ST_DONE;
                endcase
            end
            rmh_pkg::ST_UP_RD:    state_next = rmh_pkg::ST_UP_CMP;
            rmh_pkg::ST_UP_CMP:   state_next = up_move ? rmh_pkg::ST_UP_RD : rmh_pkg::ST_OP;
            rmh_pkg::ST_POP_RD:   state_next = rmh_pkg::ST_POP_WAIT;
            rmh_pkg::ST_POP_WAIT: state_next = rmh_pkg::ST_DN_RDL;
            rmh_pkg::ST_DN_RDL:   state_next = rmh_pkg::ST_DN_RDR;
            rmh_pkg::ST_DN_RDR:   state_next = rmh_pkg::ST_DN_CMP;
            rmh_pkg::ST_DN_CMP:
                state_next = (take_l || take_r) ? rmh_pkg::ST_DN_RDL : rmh_pkg::ST_OP;
            rmh_pkg::ST_DONE:     state_next = rmh_pkg::ST_IDLE;
            default:              state_next = rmh_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rmh_pkg::ST_IDLE;
            op0_reg     <= rmh_pkg::OP_NONE;
            op1_reg     <= rmh_pkg::OP_NONE;
            hp0_reg     <= 1'b0;
            hp1_reg     <= 1'b0;
            cnt_reg[0]  <= '0;
            cnt_reg[1]  <= '0;
            root_reg[0] <= '0;
            root_reg[1] <= '0;
            sample_reg  <= '0;
            carry_reg   <= '0;
            val_reg     <= '0;
            lch_reg     <= '0;
            idx_reg     <= '0;
            n_reg       <= '0;
            heap_reg    <= 1'b0;
            drop_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // roots mirror entry 0 of each heap
            if (we_c && (addr_c == '0))
            begin
                root_reg[heap_reg] <= wd_c;
            end
            unique case (state_reg)
                rmh_pkg::ST_IDLE:
                begin
                    if (start)
                    begin
                        sample_reg <= sample;
                        drop_reg   <= (total >= FULL_N);
                    end
                end
                rmh_pkg::ST_DECIDE:
                begin
                    carry_reg <= sample_reg;
                    if (drop_reg)
                    begin
                        op0_reg <= rmh_pkg::OP_NONE;
                        op1_reg <= rmh_pkg::OP_NONE;
                    end
                    else if (cnt_reg[tgt] >= DEPTH_N)
                    begin
                        // target full: go straight to the other heap or swap the root out
                        if (ord(tgt, sample_reg, root_reg[tgt]))
                        begin
                            op0_reg <= rmh_pkg::OP_PUSH;
                            hp0_reg <= !tgt;
                            op1_reg <= rmh_pkg::OP_NONE;
                        end
                        else
                        begin
                            op0_reg <= rmh_pkg::OP_REPLACE;
                            hp0_reg <= tgt;
                            op1_reg <= rmh_pkg::OP_PUSH;
                            hp1_reg <= !tgt;
                        end
                    end
                    else
                    begin
                        op0_reg <= rmh_pkg::OP_PUSH;
                        hp0_reg <= tgt;
                        op1_reg <= rmh_pkg::OP_CHECK;
                    end
                end
                rmh_pkg::ST_OP:
                begin
                    if (op0_reg == rmh_pkg::OP_CHECK)
                    begin
                        if (cnt_reg[0] > cnt_reg[1] + NW'(1))
                        begin
                            op0_reg <= rmh_pkg::OP_POP;
                            hp0_reg <= 1'b0;
                            op1_reg <= rmh_pkg::OP_PUSH;
                            hp1_reg <= 1'b1;
                        end
                        else if (cnt_reg[1] > cnt_reg[0] + NW'(1))
                        begin
                            op0_reg <= rmh_pkg::OP_POP;
                            hp0_reg <= 1'b1;
                            op1_reg <= rmh_pkg::OP_PUSH;
                            hp1_reg <= 1'b0;
                        end
                        else
                        begin
                            op0_reg <= rmh_pkg::OP_NONE;
                            op1_reg <= rmh_pkg::OP_NONE;
                        end
                    end
                    else
                    begin
                        op0_reg  <= op1_reg;
                        hp0_reg  <= hp1_reg;
                        op1_reg  <= rmh_pkg::OP_NONE;
                        heap_reg <= hp0_reg;
                        unique case (op0_reg)
                            rmh_pkg::OP_PUSH:
                            begin
                                idx_reg          <= cnt_reg[hp0_reg][AW-1:0];
                                val_reg          <= carry_reg;
                                cnt_reg[hp0_reg] <= cnt_reg[hp0_reg] + NW'(1);
                            end
                            rmh_pkg::OP_REPLACE:
                            begin
                                idx_reg   <= '0;
                                n_reg     <= cnt_reg[hp0_reg];
                                val_reg   <= carry_reg;
                                carry_reg <= root_reg[hp0_reg];
                            end
                            rmh_pkg::OP_POP:
                            begin
                                idx_reg          <= '0;
                                n_reg            <= cnt_reg[hp0_reg] - NW'(1);
                                cnt_reg[hp0_reg] <= cnt_reg[hp0_reg] - NW'(1);
                                carry_reg        <= root_reg[hp0_reg];
                            end
                            default: ;
                        endcase
                    end
                end
                rmh_pkg::ST_UP_CMP:
                begin
                    if (up_move)
                    begin
                        idx_reg <= parent;
                    end
                end
                rmh_pkg::ST_POP_WAIT:
                begin
                    val_reg <= rd;
                end
                rmh_pkg::ST_DN_RDR:
                begin
                    lch_reg <= rd;
                end
                rmh_pkg::ST_DN_CMP:
                begin
                    if (take_r)
                    begin
                        idx_reg <= rchild[AW-1:0];
                    end
                    else if (take_l)
                    begin
                        idx_reg <= lchild[AW-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (cnt_reg[0] > cnt_reg[1])
        begin
            med_c = {root_reg[0], 1'b0};
        end
        else if (cnt_reg[1] > cnt_reg[0])
        begin
            med_c = {root_reg[1], 1'b0};
        end
        else if (cnt_reg[0] == '0)
        begin
            med_c = '0;
        end
        else
        begin
            med_c = {root_reg[0][SW-1], root_reg[0]} + {root_reg[1][SW-1], root_reg[1]};
        end
    end

    assign busy           = (state_reg != rmh_pkg::ST_IDLE);
    assign done           = (state_reg == rmh_pkg::ST_DONE);
    assign median_doubled = med_c;
    assign stored_count   = CNTW'(total);
    assign full_drop      = drop_reg;

`ifndef SYNTHESIS
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");
    a_bal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cnt_reg[0] <= cnt_reg[1] + NW'(1)) && (cnt_reg[1] <= cnt_reg[0] + NW'(1)))
        else $error("heaps unbalanced");
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] <= DEPTH_N) && (cnt_reg[1] <= DEPTH_N))
        else $error("heap count above depth");
`endif

endmodule
